// ===== hdl/lpht_pkg.sv =====
`timescale 1ns / 1ps

package lpht_pkg;

    localparam int CAPACITY   = 256;
    localparam int IDX_BITS   = 8;
    localparam int KEY_BITS   = 32;
    localparam int DATA_BITS  = 32;
    localparam int CNT_BITS   = 9;
    localparam logic [31:0] HASH_MULT = 32'h9E3779B1;
    localparam logic [CNT_BITS-1:0] MAX_FILL_RESET = 9'd192;

    typedef enum logic [2:0] {
        CMD_INSERT = 3'd0,
        CMD_LOOKUP = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    typedef enum logic [3:0] {
        ST_INSERTED = 4'd0,
        ST_REPLACED = 4'd1,
        ST_FOUND    = 4'd2,
        ST_ABSENT   = 4'd3,
        ST_REMOVED  = 4'd4,
        ST_FULL     = 4'd5,
        ST_CLEARED  = 4'd6,
        ST_EMPTY    = 4'd7,
        ST_USED     = 4'd8
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HASH,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_SHIFT_RD,
        S_SHIFT_HASH,
        S_SHIFT_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]           command;
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data_in;
        logic [7:0]           slot_index;
    } in_word_t;

    typedef struct packed {
        logic [3:0]           status;
        logic [DATA_BITS-1:0] data_out;
        logic [CNT_BITS-1:0]  entry_count;
    } out_word_t;

    // Home bucket: multiplicative hash, the low index bits of the upper half (bits 23:16).
    function automatic logic [IDX_BITS-1:0] home_of(input logic [31:0] prod);
        return prod[16 +: IDX_BITS];
    endfunction

endpackage

// ===== hdl/linear_probe_hash_table_unit.sv =====
`timescale 1ns / 1ps
// Lookup and insert probe one bucket at a time, starting at the home bucket;
// remove adds a walk over the occupied buckets during backward-shift compaction,
// ended by an empty bucket or a full wrap; clear and read slot probe no bucket.
// Output stalls lengthen each command. One command at a time. Reset clears the
// valid bits, the entry count and sets max_fill to 192.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_word_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_word_t           out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CNT_BITS-1:0] cfg_data
);

    state_t state_reg, state_next;
    in_word_t cmd_reg;
    logic [CNT_BITS-1:0] max_fill_reg;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CAPACITY-1:0] occ_reg;
    logic [IDX_BITS-1:0] pos_reg, pos_next;
    logic [IDX_BITS-1:0] hole_reg, hole_next;
    logic [CNT_BITS-1:0] steps_reg, steps_next;
    logic [3:0] status_reg, status_next;
    logic [DATA_BITS-1:0] dout_reg, dout_next;

    logic [KEY_BITS-1:0]  key_mem [CAPACITY];
    logic [DATA_BITS-1:0] data_mem [CAPACITY];
    logic [KEY_BITS-1:0]  key_rd_reg;
    logic [DATA_BITS-1:0] data_rd_reg;
    logic [IDX_BITS-1:0]  rd_addr;
    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_addr;
    logic                 wr_key_en;
    logic [KEY_BITS-1:0]  wr_key;
    logic [DATA_BITS-1:0] wr_data;
    logic                 occ_set, occ_clr, occ_all_clr;
    logic [IDX_BITS-1:0]  occ_addr;

    logic [KEY_BITS-1:0] hash_key;
    logic [IDX_BITS-1:0] home;
    logic                accept;
    logic                in_range;

    lpht_hash u_hash
    (
        .clk  (clk),
        .key  (hash_key),
        .home (home)
    );

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = (state_reg == S_DONE);
    assign out_data  = '{status: status_reg, data_out: dout_reg, entry_count: count_reg};
    // The incoming key is hashed at the accepting edge so its home is ready in S_HASH.
    assign hash_key  = (state_reg == S_SHIFT_HASH) ? key_rd_reg : in_data.key;

    // Cyclic test: home lies in (hole, pos].
    always_comb
    begin
        if (hole_reg <= pos_reg)
        begin
            in_range = (home > hole_reg) && (home <= pos_reg);
        end
        else
        begin
            in_range = (home > hole_reg) || (home <= pos_reg);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (cmd_reg.command == CMD_INSERT || cmd_reg.command == CMD_LOOKUP
                    || cmd_reg.command == CMD_REMOVE)
                begin
                    state_next = S_PROBE_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PROBE_RD:
            begin
                state_next = S_PROBE_CHK;
            end
            S_PROBE_CHK:
            begin
                if (!occ_reg[pos_reg])
                begin
                    state_next = S_DONE;
                end
                else if (key_rd_reg == cmd_reg.key)
                begin
                    state_next = (cmd_reg.command == CMD_REMOVE) ? S_SHIFT_RD : S_DONE;
                end
                else if (steps_reg == CNT_BITS'(CAPACITY - 1))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PROBE_RD;
                end
            end
            S_SHIFT_RD:
            begin
                if (!occ_reg[pos_reg] || steps_reg == CNT_BITS'(CAPACITY))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_SHIFT_HASH;
                end
            end
            S_SHIFT_HASH:
            begin
                state_next = S_SHIFT_CHK;
            end
            S_SHIFT_CHK:
            begin
                state_next = S_SHIFT_RD;
            end
            S_DONE:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        pos_next    = pos_reg;
        hole_next   = hole_reg;
        steps_next  = steps_reg;
        status_next = status_reg;
        dout_next   = dout_reg;
        count_next  = count_reg;
        rd_addr     = pos_reg;
        wr_en       = 1'b0;
        wr_key_en   = 1'b0;
        wr_addr     = pos_reg;
        wr_key      = cmd_reg.key;
        wr_data     = cmd_reg.data_in;
        occ_set     = 1'b0;
        occ_clr     = 1'b0;
        occ_all_clr = 1'b0;
        occ_addr    = pos_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                // Read the requested slot while waiting, for the read slot command.
                rd_addr = in_data.slot_index[IDX_BITS-1:0];
            end
            S_HASH:
            begin
                pos_next    = home;
                steps_next  = '0;
                status_next = ST_ABSENT;
                dout_next   = '0;
                unique case (cmd_reg.command)
                    CMD_CLEAR:
                    begin
                        occ_all_clr = 1'b1;
                        count_next  = '0;
                        status_next = ST_CLEARED;
                    end
                    CMD_READ:
                    begin
                        status_next = ST_EMPTY;
                        if (occ_reg[cmd_reg.slot_index[IDX_BITS-1:0]])
                        begin
                            status_next = ST_USED;
                            dout_next   = data_rd_reg;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PROBE_CHK:
            begin
                if (!occ_reg[pos_reg])
                begin
                    if (cmd_reg.command == CMD_INSERT)
                    begin
                        if (count_reg >= max_fill_reg)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_key_en   = 1'b1;
                            occ_set     = 1'b1;
                            count_next  = count_reg + 1'b1;
                            dout_next   = cmd_reg.data_in;
                            status_next = ST_INSERTED;
                        end
                    end
                end
                else if (key_rd_reg == cmd_reg.key)
                begin
                    dout_next = data_rd_reg;
                    unique case (cmd_reg.command)
                        CMD_INSERT:
                        begin
                            wr_en       = 1'b1;
                            status_next = ST_REPLACED;
                        end
                        CMD_REMOVE:
                        begin
                            status_next = ST_REMOVED;
                            hole_next   = pos_reg;
                            pos_next    = pos_reg + 1'b1;
                            steps_next  = CNT_BITS'(1);
                        end
                        default:
                        begin
                            status_next = ST_FOUND;
                        end
                    endcase
                end
                else
                begin
                    if (steps_reg == CNT_BITS'(CAPACITY - 1) && cmd_reg.command == CMD_INSERT)
                    begin
                        status_next = ST_FULL;
                    end
                    pos_next   = pos_reg + 1'b1;
                    steps_next = steps_reg + 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                if (!occ_reg[pos_reg] || steps_reg == CNT_BITS'(CAPACITY))
                begin
                    occ_clr    = 1'b1;
                    occ_addr   = hole_reg;
                    count_next = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
                end
            end
            S_SHIFT_CHK:
            begin
                if (!in_range)
                begin
                    wr_en     = 1'b1;
                    wr_key_en = 1'b1;
                    wr_addr   = hole_reg;
                    wr_key    = key_rd_reg;
                    wr_data   = data_rd_reg;
                    hole_next = pos_reg;
                end
                pos_next   = pos_reg + 1'b1;
                steps_next = steps_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Key and data memories.
    always_ff @(posedge clk)
    begin
        key_rd_reg  <= key_mem[rd_addr];
        data_rd_reg <= data_mem[rd_addr];
        if (wr_en)
        begin
            data_mem[wr_addr] <= wr_data;
            if (wr_key_en)
            begin
                key_mem[wr_addr] <= wr_key;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            max_fill_reg <= MAX_FILL_RESET;
            count_reg    <= '0;
            occ_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready)
            begin
                max_fill_reg <= cfg_data;
            end
            if (occ_all_clr)
            begin
                occ_reg <= '0;
            end
            else if (occ_set)
            begin
                occ_reg[occ_addr] <= 1'b1;
            end
            else if (occ_clr)
            begin
                occ_reg[occ_addr] <= 1'b0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= in_data;
        end
        pos_reg    <= pos_next;
        hole_reg   <= hole_next;
        steps_reg  <= steps_next;
        status_reg <= status_next;
        dout_reg   <= dout_next;
    end

endmodule

// ===== hdl/lpht_hash.sv =====
`timescale 1ns / 1ps

// Shared hash multiplier with a registered product.
module lpht_hash
    import lpht_pkg::*;
(
    input  logic                clk,
    input  logic [KEY_BITS-1:0] key,
    output logic [IDX_BITS-1:0] home
);

    logic [31:0] prod_reg;
    logic [31:0] prod_next;

    always_comb
    begin
        prod_next = key * HASH_MULT;
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign home = home_of(prod_reg);

endmodule
